/* src/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and constants of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int DATA_W   = 8;
  localparam int CMD_W    = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } ple_status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } ple_in_t;

  typedef struct packed {
    ple_status_t       status;
    logic [CNT_W-1:0]  length;
    logic [DATA_W-1:0] read_value;
  } ple_out_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } ple_cell_ctl_t;

endpackage

/* src/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered byte list with insert, delete and read at a position
// ----------------------------------------------------------------------------
// the result strobes on out_valid in the cycle after start
// throughput: 1 item per cycle, busy stays low; the cell row shifts every
//   slot in parallel and the read is a single slot select
// reset: synchronous active-low rst_n clears the element count and strobe;
//   slot contents are not cleared, only slots below the count are read
// the receiver cannot stall, each result is shown for exactly one cycle
module positional_list_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ple_pkg::ple_in_t in_item,
  output logic             out_valid,
  output ple_pkg::ple_out_t out_item
);
  import ple_pkg::*;

  logic                accept;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  ple_out_t            out_item_r;
  ple_out_t            out_item_nxt;
  ple_cell_ctl_t       cell_ctl;
  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic [POS_W-1:0]    pos_cnt;
  ple_status_t         status;
  logic [DATA_W-1:0]   rd_value;

  // every item is taken as it arrives, so nothing is ever pending
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // position compared against the count at position width
  assign pos_cnt = POS_W'(count_r);

  // row of cells: slot g takes from g-1 on insert, from g+1 on delete
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (g == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .cell_idx   (IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .data_out   (cell_data[g])
    );
  end

  // command decode, bounds checks and count update
  always_comb begin
    cell_ctl       = '0;
    cell_ctl.pos   = in_item.position;
    cell_ctl.value = in_item.value;
    count_nxt      = count_r;
    status         = ST_OK;
    rd_value       = '0;
    case (in_item.cmd)
      CMD_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else if (in_item.position > pos_cnt) begin
          status = ST_BOUNDS;
        end else begin
          cell_ctl.ins = accept;
          count_nxt    = count_r + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (in_item.position >= pos_cnt) begin
          status = ST_BOUNDS;
        end else begin
          cell_ctl.del = accept;
          count_nxt    = count_r - 1'b1;
        end
      end
      CMD_READ: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else if (in_item.position >= pos_cnt) begin
          status = ST_BOUNDS;
        end else begin
          // position is below the count here, so the low bits index a slot
          rd_value = cell_data[in_item.position[IDX_W-1:0]];
        end
      end
      default: begin
        // reserved command leaves the list alone
        status = ST_BOUNDS;
      end
    endcase
    out_valid_nxt           = accept;
    out_item_nxt.status     = status;
    out_item_nxt.length     = count_nxt;
    out_item_nxt.read_value = rd_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload needs no reset, it is qualified by the strobe
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // every accepted item yields exactly one strobe on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result strobe without an accepted item");

  // count moves by at most one per clock and never passes capacity
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
    (count_r == $past(count_r) - 1'b1))
    else $error("count jumped by more than one");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // a full report always comes with a full list
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_FULL)) |->
      (out_item.length == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

endmodule

/* src/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds a byte and shifts toward either neighbor
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                         clk,
  input  ple_pkg::ple_cell_ctl_t       ctl,
  input  logic [ple_pkg::IDX_W-1:0]    cell_idx,
  input  logic [ple_pkg::DATA_W-1:0]   left_data,
  input  logic [ple_pkg::DATA_W-1:0]   right_data,
  output logic [ple_pkg::DATA_W-1:0]   data_out
);
  import ple_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [POS_W-1:0]  idx_ext;

  assign idx_ext = POS_W'(cell_idx);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (idx_ext == ctl.pos) begin
        data_nxt = ctl.value;
      end else if (idx_ext > ctl.pos) begin
        data_nxt = left_data;
      end
    end else if (ctl.del && (idx_ext >= ctl.pos)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

/* dv/tb_positional_list_engine.sv */
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// self-checking bench for the positional list engine
// ----------------------------------------------------------------------------
// a software copy of the byte list predicts status, length and read value for
// every accepted item; each strobed result is matched field by field against
// the oldest prediction. directed tests cover the empty list, filling to
// capacity and the out-of-bounds cases, then random traffic walks the list
// between empty and full under three sender idle profiles
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  // command code the block treats as reserved
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PROFILE = 485;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  ple_in_t  in_item = '0;
  logic     out_valid;
  ple_out_t out_item;

  // bench copy of the list contents and length
  logic [DATA_W-1:0] list_slots [CAPACITY];
  int unsigned       list_len = 0;

  // predictions waiting for their result, oldest first
  ple_out_t pending_results [$];

  int error_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;

  always #2 clk = ~clk;

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // apply one operation to the bench list and return the result it should give
  function automatic ple_out_t apply_list_op(ple_in_t op);
    ple_out_t res;
    res = '0;
    res.status = ST_OK;
    case (op.cmd)
      CMD_INSERT: begin
        // full is checked before the position, an insert past the end is dropped
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (op.position > list_len) begin
          res.status = ST_BOUNDS;
        end else begin
          for (int i = list_len; i > op.position; i--) list_slots[i] = list_slots[i-1];
          list_slots[op.position] = op.value;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (op.position >= list_len) begin
          res.status = ST_BOUNDS;
        end else begin
          for (int i = op.position; i + 1 < list_len; i++) list_slots[i] = list_slots[i+1];
          list_len--;
        end
      end
      CMD_READ: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (op.position >= list_len) begin
          res.status = ST_BOUNDS;
        end else begin
          res.read_value = list_slots[op.position];
        end
      end
      default: begin
        // reserved command leaves the list alone
        res.status = ST_BOUNDS;
      end
    endcase
    res.length = list_len[CNT_W-1:0];
    return res;
  endfunction

  // drive one item at the falling edge and hold it until the block takes it;
  // start is left high so a following item can go out back to back
  task automatic issue_list_op(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
    ple_in_t op;
    op.cmd = cmd;
    op.position = pos;
    op.value = val;
    // each sender cycle is idle with probability idle_pct percent, junk on the payload
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_item <= ple_in_t'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= op;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_op(op));
  endtask

  // every strobed result must match the oldest prediction
  always @(posedge clk) begin
    ple_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: status %0d length %0d read_value %0d",
               out_item.status, out_item.length, out_item.read_value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item.status);
          error_count++;
        end
        if (out_item.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, out_item.length);
          error_count++;
        end
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d",
                 want.read_value, out_item.read_value);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // operations on an empty list, including a dropped insert and the reserved code
  task automatic test_empty_list();
    issue_list_op(CMD_READ, 5'd0, 8'h00);
    issue_list_op(CMD_DELETE, 5'd0, 8'hFF);
    issue_list_op(CMD_INSERT, 5'd1, 8'hFF);
    issue_list_op(CMD_RESERVED, 5'd31, 8'hFF);
  endtask

  // fill to capacity mixing head, tail and middle inserts, then hit the full case
  task automatic test_fill_to_full();
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] val;
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 3)
        0:       pos = '0;
        1:       pos = POS_W'(list_len);
        default: pos = POS_W'(list_len / 2);
      endcase
      val = (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : DATA_W'(i * 8'h1B);
      issue_list_op(CMD_INSERT, pos, val);
    end
    // full wins over an out-of-range position
    issue_list_op(CMD_INSERT, 5'd31, 8'h5A);
    issue_list_op(CMD_INSERT, 5'd0, 8'hA5);
  endtask

  // positions at and past the end on a nonempty list
  task automatic test_bounds_and_edges();
    issue_list_op(CMD_READ, 5'd15, 8'h00);
    issue_list_op(CMD_READ, 5'd16, 8'h00);
    issue_list_op(CMD_DELETE, 5'd31, 8'h00);
    issue_list_op(CMD_DELETE, 5'd15, 8'h00);
    issue_list_op(CMD_DELETE, 5'd0, 8'h00);
    // length is now 14, so position 16 lies past the end
    issue_list_op(CMD_INSERT, 5'd16, 8'h77);
    issue_list_op(CMD_RESERVED, 5'd3, 8'h3C);
  endtask

  // mostly legal operations that drift the list between empty and full,
  // with some out-of-range positions and reserved codes mixed in
  task automatic test_random_traffic(int sender_idle_pct, int n_items);
    bit growing;
    int roll;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    idle_pct = sender_idle_pct;
    growing = (list_len < CAPACITY / 2);
    for (int n = 0; n < n_items; n++) begin
      if (list_len == CAPACITY) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 49) == 0) growing = !growing;
      roll = $urandom_range(0, 99);
      if (roll < 50) cmd = growing ? CMD_INSERT : CMD_DELETE;
      else if (roll < 70) cmd = growing ? CMD_DELETE : CMD_INSERT;
      else if (roll < 94) cmd = CMD_READ;
      else cmd = CMD_RESERVED;
      if ($urandom_range(0, 9) == 0) begin
        pos = POS_W'($urandom_range(0, 31));
      end else if (cmd == CMD_INSERT) begin
        pos = POS_W'($urandom_range(0, list_len));
      end else begin
        pos = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
      end
      issue_list_op(cmd, pos, DATA_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_to_full();
    test_bounds_and_edges();
    test_random_traffic(25, ITEMS_PER_PROFILE);
    test_random_traffic(77, ITEMS_PER_PROFILE);
    test_random_traffic(0, ITEMS_PER_PROFILE);

    // stop issuing before the next edge, then drain
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ple_pkg.sv
src/ple_cell.sv
src/positional_list_engine.sv
dv/tb_positional_list_engine.sv
